// File: design/steering_angle_banded_drive_assert.svh
// Assertion macros shared by the steering drive RTL.
// Depends on a clock named clk and an active-high reset named rst in the including scope.
`ifndef STEERING_ANGLE_BANDED_DRIVE_ASSERT_SVH
`define STEERING_ANGLE_BANDED_DRIVE_ASSERT_SVH
`ifndef SYNTHESIS
`define SABD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("steering drive check failed");
`define SABD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("steering drive check failed");
`else
`define SABD_ASSERT_SAME(lbl, ante, cons)
`define SABD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/sabd_pkg.sv
// Shared types, constants and band table for the steering drive pipeline.
// No dependencies; used by every stage module and the top level.
package sabd_pkg;

  localparam int COUNTS_PER_TURN = 2048;
  localparam int POS_W           = 11;
  localparam int ERR_W           = 11;
  localparam int DUTY_W          = 14;
  localparam int TGT_W           = 12;

  // 2048 / 360 reduces to 256 / 45.
  localparam int TGT_MUL   = 256;
  localparam int TGT_DIV   = 45;
  // floor(2^23 / 45); the quotient estimate is at most one short.
  localparam int RECIP     = 186413;
  localparam int RECIP_SH  = 15;
  localparam int BAND_DIV  = (8192 / COUNTS_PER_TURN < 1) ? 1 : 8192 / COUNTS_PER_TURN;
  localparam int BANDS     = 9;

  localparam logic [11:0] BAND_BASE [BANDS] =
    '{12'd2048, 12'd1024, 12'd512, 12'd256, 12'd128, 12'd64, 12'd32, 12'd26, 12'd21};
  localparam logic [DUTY_W-1:0] BAND_DUTY [BANDS] =
    '{14'd9000, 14'd5000, 14'd3000, 14'd1400, 14'd1300, 14'd1250, 14'd1200, 14'd1150,
      14'd1000};

  typedef enum logic [1:0] {
    MODE_BRAKE    = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TGT_W-1:0] quot_est;
    logic [8:0]       target;
    logic [POS_W-1:0] pos;
    logic             motor;
  } s1_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [POS_W-1:0]        pos;
    logic                    motor;
  } s2_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    mode_t                   mode;
    logic signed [ERR_W-1:0] err;
    logic [POS_W-1:0]        pos;
    logic                    motor;
  } res_t;

endpackage

// File: design/sabd_target.sv
// Stage one: folds the encoder count into one turn and estimates the target in counts.
// Depends on sabd_pkg.
module sabd_target (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] count,
  input  logic [8:0]         target,
  input  logic               motor,
  output logic               out_valid,
  input  logic               out_ready,
  output sabd_pkg::s1_t      out_data
);
  import sabd_pkg::*;

  logic [26:0] prod;

  // The turn is a power of two, so the non-negative residue is the low bits.
  assign prod     = 27'(target) * 27'(RECIP);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.quot_est <= TGT_W'(prod >> RECIP_SH);
      out_data.target   <= target;
      out_data.pos      <= count[POS_W-1:0];
      out_data.motor    <= motor;
    end
  end
endmodule

// File: design/sabd_error.sv
// Stage two: corrects the target quotient and forms the shortest wrap-around error.
// Depends on sabd_pkg.
module sabd_error (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sabd_pkg::s1_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sabd_pkg::s2_t out_data
);
  import sabd_pkg::*;

  logic [16:0]      numer;
  logic [16:0]      back;
  logic [16:0]      rem;
  logic [TGT_W-1:0] tgt;

  always_comb begin
    numer = 17'(in_data.target) * 17'(TGT_MUL);
    back  = 17'(in_data.quot_est) * 17'(TGT_DIV);
    rem   = numer - back;
    tgt   = (rem >= 17'(TGT_DIV)) ? in_data.quot_est + 1'b1 : in_data.quot_est;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      // Offsetting by half a turn and folding equals a wrapping difference read as signed.
      out_data.err   <= signed'(tgt[ERR_W-1:0] - in_data.pos);
      out_data.pos   <= in_data.pos;
      out_data.motor <= in_data.motor;
    end
  end
endmodule

// File: design/sabd_band.sv
// Stage three: picks the duty from the falling band table and sets the drive mode.
// Depends on sabd_pkg.
module sabd_band (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sabd_pkg::s2_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sabd_pkg::res_t out_data
);
  import sabd_pkg::*;

  logic [ERR_W-1:0]  mag;
  logic [DUTY_W-1:0] duty;
  mode_t             mode;

  always_comb begin
    mag  = in_data.err[ERR_W-1] ? ERR_W'(-in_data.err) : ERR_W'(in_data.err);
    duty = '0;
    // Walk from the smallest band up so that the largest matching band wins.
    for (int i = BANDS - 1; i >= 0; i--) begin
      if ({1'b0, mag} >= 12'(BAND_BASE[i] / BAND_DIV)) begin
        duty = BAND_DUTY[i];
      end
    end
    if (duty == '0) begin
      mode = MODE_BRAKE;
    end else if (!in_data.err[ERR_W-1] && in_data.err != '0) begin
      mode = MODE_FORWARD;
    end else begin
      mode = MODE_BACKWARD;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.duty  <= duty;
      out_data.mode  <= mode;
      out_data.err   <= in_data.err;
      out_data.pos   <= in_data.pos;
      out_data.motor <= in_data.motor;
    end
  end
endmodule

// File: design/steering_angle_banded_drive.sv
// Top level of the steering drive: three-stage pipeline from encoder sample to duty.
// Depends on sabd_pkg, sabd_target, sabd_error, sabd_band and the assertion header.
//
// Each transfer on the input stream carries one encoder sample and gives exactly one
// transfer on the output stream, in order. The block keeps no state between samples.
// It accepts one sample every cycle as long as the output does not stall. A result passes
// through the stage one and stage two registers, in that order, to the output register. The
// result sits in the output register until it is taken. The three stages are
// the reciprocal multiply that scales degrees to counts, the quotient correction with
// the wrap-around error, and the band table lookup. Each stage moves whenever the one
// after it is empty or moving. A stall on the output therefore holds the input only once
// every stage is full, which in a steady back-to-back stream is at once. Nothing is
// dropped or repeated. The turn is 2048 counts; the folded position is the low bits of
// the count.
`include "steering_angle_banded_drive_assert.svh"
module steering_angle_banded_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // encoder_count[31:0], target_angle[40:32], zero fill
  input  logic        s_tuser,   // motor_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // drive_duty[13:0], drive_mode[15:14], angle_error[26:16],
                                 // wrapped_position[37:27], zero fill
  output logic        m_tuser    // motor_out
);
  import sabd_pkg::*;

  logic v1;
  logic r1;
  s1_t  d1;
  logic v2;
  logic r2;
  s2_t  d2;
  res_t res;

  sabd_target u_target (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .count     (signed'(s_tdata[31:0])),
    .target    (s_tdata[40:32]),
    .motor     (s_tuser),
    .out_valid (v1),
    .out_ready (r1),
    .out_data  (d1)
  );

  sabd_error u_error (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r2),
    .out_data  (d2)
  );

  sabd_band u_band (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_data   (d2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {2'b00, res.pos, res.err, res.mode, res.duty};
  assign m_tuser = res.motor;

  // A zero duty always means brake, and brake always means zero duty.
  `SABD_ASSERT_SAME(a_brake_duty, m_tvalid, (res.duty == '0) == (res.mode == MODE_BRAKE))
  // Forward drive only for a strictly positive error.
  `SABD_ASSERT_SAME(a_fwd_sign, m_tvalid && res.mode == MODE_FORWARD,
                    !res.err[ERR_W-1] && res.err != '0)
  // The input side only stalls when the output holds an untaken result.
  `SABD_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready)
  // A stalled result does not change.
  `SABD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
